/* rtl/core/lss_pkg.sv */
// shared types and constants for the lifo stack with sort
// no dependencies
package lss_pkg;

    localparam int DEPTH_DEF     = 128;
    localparam int WORD_BITS_DEF = 32;
    localparam int IN_BITS       = 32;
    localparam int OUT_BITS      = 32;
    localparam int POS_BITS      = 7;
    localparam int FILL_BITS     = 8;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_SORT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_SORT  = 3'd3,
        OP_FULL  = 3'd4,
        OP_EMPTY = 3'd5
    } op_t;

    localparam int OP_BITS = $bits(op_t);

endpackage

/* rtl/core/lss_front.sv */
// front end: takes commands, tracks the fill level and classifies each transfer
// depends on lss_pkg
module lss_front #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              q_full,
    input  logic [1:0]                        cmd,
    input  logic signed [lss_pkg::IN_BITS-1:0] push_value,
    output logic                              item_valid,
    output lss_pkg::op_t                      item_op,
    output logic [$clog2(DEPTH)-1:0]          item_addr,
    output logic [$clog2(DEPTH+1)-1:0]        item_fill,
    output logic [WORD_BITS-1:0]              item_word
);
    import lss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                occ_reg;
    logic [CW-1:0]                occ_next;
    logic [WORD_BITS+IN_BITS-1:0] ext_word;

    assign ext_word   = {{WORD_BITS{push_value[IN_BITS-1]}}, push_value};
    assign item_word  = ext_word[WORD_BITS-1:0];
    assign item_valid = start && !q_full;

    always_comb
    begin
        occ_next  = occ_reg;
        item_op   = OP_EMPTY;
        item_addr = '0;
        item_fill = occ_reg;
        if (cmd_t'(cmd) == CMD_PUSH)
        begin
            if (occ_reg == CW'(DEPTH))
            begin
                item_op = OP_FULL;
            end
            else
            begin
                item_op   = OP_PUSH;
                item_addr = occ_reg[AW-1:0];
                item_fill = occ_reg + CW'(1);
                occ_next  = occ_reg + CW'(1);
            end
        end
        else if (occ_reg != '0)
        begin
            case (cmd_t'(cmd))
                CMD_POP:
                begin
                    item_op   = OP_POP;
                    item_addr = AW'(occ_reg - CW'(1));
                    item_fill = occ_reg - CW'(1);
                    occ_next  = occ_reg - CW'(1);
                end
                CMD_PEEK:
                begin
                    item_op   = OP_PEEK;
                    item_addr = AW'(occ_reg - CW'(1));
                end
                CMD_SORT:
                begin
                    item_op = OP_SORT;
                end
                default:
                begin
                    item_op = OP_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (item_valid)
        begin
            occ_reg <= occ_next;
        end
    end

endmodule

/* rtl/core/lss_queue.sv */
// two-entry queue between front and back
// no dependencies
module lss_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/lss_back.sv */
// back end: word memory, command execution and compare-swap sort sequencer
// depends on lss_pkg
module lss_back #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  logic [lss_pkg::OP_BITS+$clog2(DEPTH)+$clog2(DEPTH+1)+WORD_BITS-1:0] q_data,
    output logic                                q_rd,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [lss_pkg::OUT_BITS-1:0] data_out,
    output logic [lss_pkg::POS_BITS-1:0]        position,
    output logic [lss_pkg::FILL_BITS-1:0]       fill_count
);
    import lss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SRD0,
        S_SLOAD,
        S_SCMP,
        S_SEND
    } state_t;

    function automatic logic [OUT_BITS-1:0] from_word(input logic [WORD_BITS-1:0] w);
        logic [OUT_BITS+WORD_BITS-1:0] ext;
        ext = {{OUT_BITS{w[WORD_BITS-1]}}, w};
        return ext[OUT_BITS-1:0];
    endfunction

    function automatic logic [POS_BITS-1:0] to_pos(input logic [AW-1:0] a);
        logic [POS_BITS+AW-1:0] ext;
        ext = {{POS_BITS{1'b0}}, a};
        return ext[POS_BITS-1:0];
    endfunction

    function automatic logic [FILL_BITS-1:0] to_fill(input logic [CW-1:0] f);
        logic [FILL_BITS+CW-1:0] ext;
        ext = {{FILL_BITS{1'b0}}, f};
        return ext[FILL_BITS-1:0];
    endfunction

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [OP_BITS-1:0]   in_op_bits;
    op_t                  in_op;
    logic [AW-1:0]        in_addr;
    logic [CW-1:0]        in_fill;
    logic [WORD_BITS-1:0] in_word;

    state_t               state_reg, state_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [WORD_BITS-1:0] carry_reg, carry_next;
    logic [AW-1:0]        hold_addr_reg, hold_addr_next;
    logic [CW-1:0]        hold_fill_reg, hold_fill_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [OUT_BITS-1:0]  data_reg, data_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;

    logic                 we;
    logic [AW-1:0]        wa;
    logic [WORD_BITS-1:0] wd;
    logic [AW-1:0]        ra;
    logic                 greater;

    assign {in_op_bits, in_addr, in_fill, in_word} = q_data;
    assign in_op   = op_t'(in_op_bits);
    assign greater = $signed(carry_reg) > $signed(rd_data_reg);

    assign done       = done_reg;
    assign status     = status_reg;
    assign data_out   = data_reg;
    assign position   = pos_reg;
    assign fill_count = fill_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        carry_next     = carry_reg;
        hold_addr_next = hold_addr_reg;
        hold_fill_next = hold_fill_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        data_next      = data_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        we             = 1'b0;
        wa             = '0;
        wd             = '0;
        ra             = k_reg;
        q_rd           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd = 1'b1;
                    case (in_op)
                        OP_PUSH:
                        begin
                            we          = 1'b1;
                            wa          = in_addr;
                            wd          = in_word;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            data_next   = from_word(in_word);
                            pos_next    = to_pos(in_addr);
                            fill_next   = to_fill(in_fill);
                        end
                        OP_POP, OP_PEEK:
                        begin
                            ra             = in_addr;
                            hold_addr_next = in_addr;
                            hold_fill_next = in_fill;
                            state_next     = S_READ;
                        end
                        OP_SORT:
                        begin
                            if (in_fill < CW'(2))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_OK;
                                data_next   = '0;
                                pos_next    = '0;
                                fill_next   = to_fill(in_fill);
                            end
                            else
                            begin
                                last_next      = AW'(in_fill - CW'(1));
                                hold_fill_next = in_fill;
                                state_next     = S_SRD0;
                            end
                        end
                        OP_FULL:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OVERFLOW;
                            data_next   = '0;
                            pos_next    = '0;
                            fill_next   = to_fill(in_fill);
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                            data_next   = '0;
                            pos_next    = '0;
                            fill_next   = to_fill(in_fill);
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                data_next   = from_word(rd_data_reg);
                pos_next    = to_pos(hold_addr_reg);
                fill_next   = to_fill(hold_fill_reg);
                state_next  = S_IDLE;
            end
            S_SRD0:
            begin
                ra         = '0;
                k_next     = '0;
                state_next = S_SLOAD;
            end
            S_SLOAD:
            begin
                carry_next = rd_data_reg;
                ra         = k_reg + AW'(1);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                we         = 1'b1;
                wa         = k_reg;
                wd         = greater ? rd_data_reg : carry_reg;
                carry_next = greater ? carry_reg : rd_data_reg;
                k_next     = k_reg + AW'(1);
                if (k_reg + AW'(1) == last_reg)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    ra = k_reg + AW'(2);
                end
            end
            S_SEND:
            begin
                we = 1'b1;
                wa = last_reg;
                wd = carry_reg;
                if (last_reg == AW'(1))
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    pos_next    = '0;
                    fill_next   = to_fill(hold_fill_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    last_next  = last_reg - AW'(1);
                    state_next = S_SRD0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        last_reg      <= last_next;
        carry_reg     <= carry_next;
        hold_addr_reg <= hold_addr_next;
        hold_fill_reg <= hold_fill_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
        pos_reg       <= pos_next;
        fill_reg      <= fill_next;
    end

endmodule

/* rtl/core/lifo_stack_with_sort.sv */
// top level of the lifo stack with sort: front end, two-entry queue, back end
// depends on lss_pkg, lss_front, lss_queue, lss_back
//
// usage:
//   a command (cmd, push_value) transfers at a rising edge with start high and
//   busy low. cmd: push, pop, peek or sort. every command gives one result on
//   status, data_out, position and fill_count, marked by done for one cycle.
//   the front end keeps the fill level and classifies each command at once
//   (overflow on a full push, empty on pop, peek or sort with nothing stored);
//   a two-entry queue decouples it from the back end, which owns the memory.
//   results pass through the queue and a registered back-end step; pop and peek
//   add a read state; a sort runs passes of read, load, compare-swap and end
//   states with one read and one write port, one compare-swap per cycle in a
//   pass. while idle the back end takes one push per cycle.
//   busy is high while the queue holds two commands.
//   reset clears the fill level, the queue and the back-end state; the stack
//   is empty afterwards. results are always taken; there is no stall input.
module lifo_stack_with_sort #(
    parameter int DEPTH     = lss_pkg::DEPTH_DEF,
    parameter int WORD_BITS = lss_pkg::WORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic signed [lss_pkg::IN_BITS-1:0]  push_value,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [lss_pkg::OUT_BITS-1:0] data_out,
    output logic [lss_pkg::POS_BITS-1:0]        position,
    output logic [lss_pkg::FILL_BITS-1:0]       fill_count
);
    import lss_pkg::*;

    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int ITEM_BITS = OP_BITS + AW + CW + WORD_BITS;

    logic                 item_valid;
    op_t                  item_op;
    logic [AW-1:0]        item_addr;
    logic [CW-1:0]        item_fill;
    logic [WORD_BITS-1:0] item_word;
    logic [ITEM_BITS-1:0] q_wr_data;
    logic [ITEM_BITS-1:0] q_rd_data;
    logic                 q_rd;
    logic                 q_full;
    logic                 q_empty;

    assign busy      = q_full;
    assign q_wr_data = {item_op, item_addr, item_fill, item_word};

    lss_front #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .q_full     (q_full),
        .cmd        (cmd),
        .push_value (push_value),
        .item_valid (item_valid),
        .item_op    (item_op),
        .item_addr  (item_addr),
        .item_fill  (item_fill),
        .item_word  (item_word)
    );

    lss_queue #(
        .WIDTH (ITEM_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (item_valid),
        .wr_data (q_wr_data),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    lss_back #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_rd       (q_rd),
        .done       (done),
        .status     (status),
        .data_out   (data_out),
        .position   (position),
        .fill_count (fill_count)
    );

endmodule

/* tb/lifo_stack_with_sort_test.sv */
// self-checking testbench for lifo_stack_with_sort: directed and random command streams
// a scoreboard class keeps its own copy of the stack and checks every result
// depends on lss_pkg and the lifo_stack_with_sort rtl
module lifo_stack_with_sort_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lss_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int ITEMS = 1600;

    typedef struct packed {
        status_t                   status;
        logic signed [OUT_BITS-1:0] data;
        logic [POS_BITS-1:0]       pos;
        logic [FILL_BITS-1:0]      fill;
    } stack_result_t;

    class stack_scoreboard;
        logic signed [OUT_BITS-1:0] words [DEPTH];
        int unsigned fill;
        stack_result_t expected_q [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned overflows;
        int unsigned empties;
        int unsigned sorts;
        int unsigned full_sorts;

        function new();
            fill = 0;
            mismatches = 0;
            results_seen = 0;
            overflows = 0;
            empties = 0;
            sorts = 0;
            full_sorts = 0;
        endfunction

        function void note_command(cmd_t c, logic signed [IN_BITS-1:0] v);
            stack_result_t r;
            logic signed [OUT_BITS-1:0] t;
            int pass;
            int k;
            r.status = ST_OK;
            r.data = '0;
            r.pos = '0;
            if (c == CMD_PUSH)
            begin
                if (fill >= DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                    overflows++;
                end
                else
                begin
                    words[fill] = v;
                    r.data = v;
                    r.pos = POS_BITS'(fill);
                    fill++;
                end
            end
            else if (fill == 0)
            begin
                r.status = ST_EMPTY;
                empties++;
            end
            else if (c == CMD_POP)
            begin
                fill--;
                r.data = words[fill];
                r.pos = POS_BITS'(fill);
            end
            else if (c == CMD_PEEK)
            begin
                r.data = words[fill - 1];
                r.pos = POS_BITS'(fill - 1);
            end
            else
            begin
                sorts++;
                if (fill == DEPTH)
                    full_sorts++;
                for (pass = 0; pass + 1 < fill; pass++)
                begin
                    for (k = 0; k + 1 < fill - pass; k++)
                    begin
                        if (words[k] > words[k + 1])
                        begin
                            t = words[k];
                            words[k] = words[k + 1];
                            words[k + 1] = t;
                        end
                    end
                end
            end
            r.fill = FILL_BITS'(fill);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [OUT_BITS-1:0] d,
                                   logic [POS_BITS-1:0] p, logic [FILL_BITS-1:0] f);
            stack_result_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d data %0d position %0d fill %0d",
                             st, d, p, f);
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status || d !== e.data || p !== e.pos || f !== e.fill)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t: expected status %0d data %0d position %0d fill %0d",
                             $realtime, e.status, e.data, e.pos, e.fill);
                    $display("                 actual   status %0d data %0d position %0d fill %0d",
                             st, d, p, f);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  cmd;
    logic signed [IN_BITS-1:0]   push_value;
    logic                        done;
    logic [1:0]                  status;
    logic signed [OUT_BITS-1:0]  data_out;
    logic [POS_BITS-1:0]         position;
    logic [FILL_BITS-1:0]        fill_count;

    stack_scoreboard sb;
    int unsigned sent;
    int unsigned idle_pct;

    lifo_stack_with_sort u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .push_value (push_value),
        .done       (done),
        .status     (status),
        .data_out   (data_out),
        .position   (position),
        .fill_count (fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(40_000_000);
        $display("FAIL lifo_stack_with_sort");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(status, data_out, position, fill_count);
    end

    function automatic logic signed [IN_BITS-1:0] rand_word();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return int'($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input cmd_t c, input logic signed [IN_BITS-1:0] v);
        idle_pct = (sent >= 500 && sent < 800) ? 0 : 37;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        push_value <= v;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_command(c, v);
        sent++;
    endtask

    initial
    begin
        cmd_t c;
        int pick;
        int n;
        int seq;
        sb = new();
        sent = 0;
        idle_pct = 37;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= CMD_PUSH;
        push_value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, every command, empty stack, single-word sort, duplicates
        send_command(CMD_PUSH, 32'sh7fffffff);
        send_command(CMD_PUSH, 32'sh80000000);
        send_command(CMD_PUSH, 32'sh00000000);
        send_command(CMD_PUSH, -32'sd1);
        send_command(CMD_PEEK, 32'sh12345678);
        send_command(CMD_SORT, '0);
        send_command(CMD_PEEK, '0);
        repeat (5) send_command(CMD_POP, -32'sd1);
        send_command(CMD_PEEK, '0);
        send_command(CMD_SORT, '0);
        send_command(CMD_PUSH, 32'sh5a5a5a5a);
        send_command(CMD_SORT, '0);
        send_command(CMD_POP, '0);
        send_command(CMD_PUSH, 32'sd3);
        send_command(CMD_PUSH, -32'sd7);
        send_command(CMD_PUSH, 32'sd3);
        send_command(CMD_PUSH, 32'sd1);
        send_command(CMD_SORT, '0);
        repeat (4) send_command(CMD_POP, '0);

        while (sent < ITEMS + 25)
        begin
            seq = $urandom_range(99);
            if (seq < 15)
            begin
                while (sb.fill < DEPTH)
                    send_command(CMD_PUSH, rand_word());
                n = $urandom_range(4, 1);
                repeat (n) send_command(CMD_PUSH, rand_word());
                if ($urandom_range(1) == 1)
                    send_command(CMD_SORT, rand_word());
                send_command(CMD_PEEK, rand_word());
                send_command(CMD_POP, rand_word());
                send_command(CMD_PUSH, rand_word());
                send_command(CMD_PUSH, rand_word());
            end
            else if (seq < 30)
            begin
                while (sb.fill > 0)
                    send_command(($urandom_range(99) < 80) ? CMD_POP : CMD_PEEK, rand_word());
                n = $urandom_range(3, 1);
                repeat (n) send_command(cmd_t'($urandom_range(3, 1)), rand_word());
            end
            else if (seq < 40)
            begin
                // narrow value range so sorts see many equal words
                repeat (20)
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        c = CMD_PUSH;
                    else if (pick < 70)
                        c = (sb.fill <= 32) ? CMD_SORT : CMD_PEEK;
                    else if (pick < 85)
                        c = CMD_POP;
                    else
                        c = CMD_PEEK;
                    send_command(c, int'($urandom_range(6)) - 3);
                end
            end
            else
            begin
                repeat (30)
                begin
                    pick = $urandom_range(99);
                    if (pick < 35)
                        c = CMD_PUSH;
                    else if (pick < 70)
                        c = CMD_POP;
                    else if (pick < 90)
                        c = CMD_PEEK;
                    else
                        c = (sb.fill <= 32) ? CMD_SORT : CMD_PEEK;
                    send_command(c, rand_word());
                end
            end
        end
        start <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d commands and %0d results, %0d sorts of which %0d on a full stack",
                 sent, sb.results_seen, sb.sorts, sb.full_sorts);
        $display("error paths seen: %0d pushes on a full stack, %0d commands on an empty stack",
                 sb.overflows, sb.empties);
        if (sb.mismatches == 0)
            $display("PASS lifo_stack_with_sort");
        else
        begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("FAIL lifo_stack_with_sort");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/lss_pkg.sv
rtl/core/lss_front.sv
rtl/core/lss_queue.sv
rtl/core/lss_back.sv
rtl/core/lifo_stack_with_sort.sv
tb/lifo_stack_with_sort_test.sv
